// ===== rtl/core/hrpr_pkg.sv =====
// Types, register indexes and constant tables for the hopping RC packet receiver.
// Self-contained; imported by hopping_rc_packet_receiver.
`default_nettype none

package hrpr_pkg;

   // Hop table geometry
   localparam int HOP_LEN   = 16;
   localparam int HOP_IDX_W = $clog2(HOP_LEN);
   localparam int IDLE_W    = 17;

   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

   // Input command codes
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_PACKET = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_BIND   = 2'd1;
   localparam logic [1:0] KIND_CHAN   = 2'd2;
   localparam logic [1:0] KIND_RETUNE = 2'd3;

   // Channel numbers
   localparam logic [3:0] CH_THROTTLE = 4'd0;
   localparam logic [3:0] CH_YAW      = 4'd1;
   localparam logic [3:0] CH_PITCH    = 4'd2;
   localparam logic [3:0] CH_ROLL     = 4'd3;
   localparam logic [3:0] CH_LED      = 4'd4;
   localparam logic [3:0] CH_FLIP     = 4'd5;
   localparam logic [3:0] CH_CAMERA   = 4'd6;
   localparam logic [3:0] CH_VIDEO    = 4'd7;
   localparam logic [3:0] CH_HEADLESS = 4'd8;
   localparam logic [3:0] CH_MAG_X    = 4'd9;
   localparam logic [3:0] CH_MAG_Y    = 4'd10;

   // Flag masks
   localparam logic [7:0] BIND_MASK     = 8'hC0;
   localparam logic [7:0] MODE_CAMERA   = 8'h01;
   localparam logic [7:0] MODE_VIDEO    = 8'h02;
   localparam logic [7:0] MODE_FLIP     = 8'h04;
   localparam logic [7:0] MODE_LED      = 8'h10;
   localparam logic [7:0] AUX_HEADLESS  = 8'h02;
   localparam logic [7:0] AUX_MAG_X     = 8'h08;
   localparam logic [7:0] AUX_MAG_Y     = 8'h20;

   // Stick scaling: floor(b * 1000 / 255) == (b * SCALE_MULT) >> SCALE_SHIFT for 8-bit b
   localparam int          SCALE_SHIFT  = 16;
   localparam logic [17:0] SCALE_MULT   = 18'd257004;
   localparam logic [11:0] SCALE_OFFSET = 12'd1000;

   // Hop table entries whose low nibble lands on zero are pulled down by this much
   localparam logic [7:0] HOP_FIX = 8'd3;

   // Register reset values
   localparam logic [11:0] PWM_LOW_RESET      = 12'd1000;
   localparam logic [11:0] PWM_HIGH_RESET     = 12'd2000;
   localparam logic [15:0] BIND_TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] DATA_TIMEOUT_RESET = 16'd10000;

   typedef enum logic [1:0] {
      CSR_PWM_LOW      = 2'd0,
      CSR_PWM_HIGH     = 2'd1,
      CSR_BIND_TIMEOUT = 2'd2,
      CSR_DATA_TIMEOUT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] throttle_byte;
      logic [7:0] yaw_byte;
      logic [7:0] pitch_byte;
      logic [7:0] roll_byte;
      logic [7:0] id_first;
      logic [7:0] id_second;
      logic [7:0] id_third;
      logic [7:0] aux_flags;
      logic [7:0] mode_flags;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  rf_channel;
      logic [3:0]  channel_number;
      logic [11:0] channel_value;
      logic        last;
   } rsp_type;

   // Base hopping rows; the bound table is one row plus an offset
   localparam logic [5:0] BASE_ROWS [4][HOP_LEN] = '{
      '{6'h27, 6'h1B, 6'h39, 6'h28, 6'h24, 6'h22, 6'h2E, 6'h36,
        6'h19, 6'h21, 6'h29, 6'h14, 6'h1E, 6'h12, 6'h2D, 6'h18},
      '{6'h2E, 6'h33, 6'h25, 6'h38, 6'h19, 6'h12, 6'h18, 6'h16,
        6'h2A, 6'h1C, 6'h1F, 6'h37, 6'h2F, 6'h23, 6'h34, 6'h10},
      '{6'h11, 6'h1A, 6'h35, 6'h24, 6'h28, 6'h18, 6'h25, 6'h2A,
        6'h32, 6'h2C, 6'h14, 6'h27, 6'h36, 6'h34, 6'h1C, 6'h17},
      '{6'h22, 6'h27, 6'h17, 6'h39, 6'h34, 6'h28, 6'h2B, 6'h1D,
        6'h18, 6'h2A, 6'h21, 6'h38, 6'h10, 6'h26, 6'h20, 6'h1F}
   };

   // Switch state for a switch channel
   function automatic logic switch_flag(input logic [3:0] chn, input logic [7:0] mode,
                                        input logic [7:0] aux);
      logic flag;
      flag = 1'b0;
      case (chn)
         CH_LED:      flag = (mode & MODE_LED) != 8'h00;
         CH_FLIP:     flag = (mode & MODE_FLIP) != 8'h00;
         CH_CAMERA:   flag = (mode & MODE_CAMERA) != 8'h00;
         CH_VIDEO:    flag = (mode & MODE_VIDEO) != 8'h00;
         CH_HEADLESS: flag = (aux & AUX_HEADLESS) != 8'h00;
         CH_MAG_X:    flag = (aux & AUX_MAG_X) != 8'h00;
         CH_MAG_Y:    flag = (aux & AUX_MAG_Y) != 8'h00;
         default:     flag = 1'b0;
      endcase
      return flag;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hopping_rc_packet_receiver.sv =====
// Receiver core of a frequency-hopping RC link: timeout hopping, binding and channel decode.
// Depends on hrpr_pkg for payload types, register indexes and the base hop rows.
//
// Usage
//   req_*  : one word per microsecond tick (cmd 0) or per decoded packet (cmd 1).
//   rsp_*  : result words; the final word caused by a request carries last.
//   csr_*  : register writes (pwm_low, pwm_high, bind and data timeouts), always ready.
//            Write registers only while the block is idle.
// Timing
//   A tick that does not time out gives no word. A tick that times out gives one
//   retune word, registered through the retune state and then the output register.
//   A packet gives a retune word, then a bind word or eleven channel words (a bound
//   packet from a foreign id gives the retune word alone), one word per cycle while
//   the output register is free, from a shared scaling multiplier and switch selector.
//   A bind that takes the id rebuilds the hop table one entry per cycle after the bind word.
//   req_ready is high only in the idle state; a finished word may still sit in the
//   output register while the next request is taken.
// Reset
//   Synchronous. Loads hop table row zero, hop index one, unbound, bind timeout
//   active and the register defaults.
// Back-pressure
//   With rsp_ready low, hold the output word and stall the word-emitting states; nothing drops.
`default_nettype none

module hopping_rc_packet_receiver (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire hrpr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output hrpr_pkg::rsp_type      rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire hrpr_pkg::csr_index_type csr_index,
   input  wire  [15:0]            csr_data
);
   import hrpr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_RETUNE = 5'b00010,
      ST_BIND   = 5'b00100,
      ST_BUILD  = 5'b01000,
      ST_CHAN   = 5'b10000
   } state_type;

   // Sequencer state
   state_type            state_ff, state_in;
   logic [3:0]           cnt_ff, cnt_in;
   req_type              item_ff, item_in;

   // Link state
   logic [5:0]           hop_table_ff [HOP_LEN];
   logic [HOP_IDX_W-1:0] hop_index_ff, hop_index_in;
   logic                 bound_ff, bound_in;
   logic [23:0]          stored_id_ff, stored_id_in;
   logic [IDLE_W-1:0]    idle_ff, idle_in;
   logic                 use_data_ff, use_data_in;
   logic [1:0]           row_ff, row_in;
   logic [2:0]           inc_ff, inc_in;

   // Registers
   logic [11:0]          pwm_low_ff, pwm_high_ff;
   logic [15:0]          bind_timeout_ff, data_timeout_ff;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Datapath
   logic                 out_free;
   logic                 load;
   rsp_type              emit;
   logic [15:0]          limit;
   logic [IDLE_W-1:0]    idle_step;
   logic                 bind_bits;
   logic                 id_match;
   logic [23:0]          item_id;
   logic [7:0]           id_sum;
   logic                 retune_last;
   logic [7:0]           stick_sel;
   logic [7:0]           mult_in;
   logic [25:0]          product;
   logic [11:0]          scaled;
   logic [11:0]          chan_value;
   logic [7:0]           base_sum;
   logic [7:0]           base_fixed;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign limit     = use_data_ff ? data_timeout_ff : bind_timeout_ff;
   assign idle_step = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 17'd1;

   assign item_id   = {item_ff.id_third, item_ff.id_second, item_ff.id_first};
   assign id_sum    = item_ff.id_first + item_ff.id_second + item_ff.id_third;
   assign bind_bits = (item_ff.mode_flags & BIND_MASK) == BIND_MASK;
   assign id_match  = (item_id == stored_id_ff);

   // Retune closes the sequence for a tick and for a bound packet from a foreign id
   assign retune_last = (item_ff.cmd == CMD_TICK) || (bound_ff && !bind_bits && !id_match);

   // Shared scaling unit: fold a stick (not the throttle) about centre, multiply by 1000/255, add the offset
   always_comb begin
      case (cnt_ff)
         CH_YAW:   stick_sel = item_ff.yaw_byte;
         CH_PITCH: stick_sel = item_ff.pitch_byte;
         default:  stick_sel = item_ff.roll_byte;
      endcase
      if (cnt_ff == CH_THROTTLE) begin
         mult_in = item_ff.throttle_byte;
      end else if (!stick_sel[7]) begin
         mult_in = {1'b0, ~stick_sel[6:0]};
      end else begin
         mult_in = stick_sel;
      end
   end

   assign product = {18'd0, mult_in} * {8'd0, SCALE_MULT};
   assign scaled  = {2'b00, product[25:SCALE_SHIFT]} + SCALE_OFFSET;

   assign chan_value = (cnt_ff <= CH_ROLL) ? scaled :
                       (switch_flag(cnt_ff, item_ff.mode_flags, item_ff.aux_flags)
                        ? pwm_high_ff : pwm_low_ff);

   // Table build: base row plus offset, nudge entries that end on a zero nibble
   assign base_sum   = {2'b00, BASE_ROWS[row_ff][cnt_ff]} + {5'd0, inc_ff};
   assign base_fixed = (base_sum[3:0] == 4'h0) ? base_sum - HOP_FIX : base_sum;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      hop_index_in = hop_index_ff;
      bound_in     = bound_ff;
      stored_id_in = stored_id_ff;
      idle_in      = idle_ff;
      use_data_in  = use_data_ff;
      row_in       = row_ff;
      inc_in       = inc_ff;
      load         = 1'b0;
      emit         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               if (req_data.cmd == CMD_PACKET) begin
                  idle_in  = '0;
                  state_in = ST_RETUNE;
               end else if (idle_step > {1'b0, limit}) begin
                  idle_in  = '0;
                  state_in = ST_RETUNE;
               end else begin
                  idle_in = idle_step;
               end
            end
         end
         ST_RETUNE: begin
            if (out_free) begin
               load            = 1'b1;
               emit.kind       = KIND_RETUNE;
               emit.rf_channel = {1'b0, hop_table_ff[hop_index_ff]};
               emit.last       = retune_last;
               hop_index_in    = (hop_index_ff == HOP_IDX_W'(HOP_LEN - 1)) ?
                                 '0 : hop_index_ff + 1'b1;
               if (item_ff.cmd == CMD_TICK) begin
                  state_in = ST_IDLE;
               end else if (!bound_ff || bind_bits) begin
                  state_in = ST_BIND;
               end else if (id_match) begin
                  use_data_in = 1'b1;
                  cnt_in      = CH_THROTTLE;
                  state_in    = ST_CHAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BIND: begin
            if (out_free) begin
               load      = 1'b1;
               emit.kind = KIND_BIND;
               emit.last = 1'b1;
               if (!bound_ff && bind_bits) begin
                  stored_id_in = item_id;
                  bound_in     = 1'b1;
                  use_data_in  = 1'b0;
                  row_in       = id_sum[1:0];
                  inc_in       = id_sum[4:2];
                  cnt_in       = '0;
                  state_in     = ST_BUILD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BUILD: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(HOP_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHAN: begin
            if (out_free) begin
               load                = 1'b1;
               emit.kind           = KIND_CHAN;
               emit.channel_number = cnt_ff;
               emit.channel_value  = chan_value;
               emit.last           = (cnt_ff == CH_MAG_Y);
               cnt_in              = cnt_ff + 4'd1;
               if (cnt_ff == CH_MAG_Y) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Output register: load a fresh word, else drop the one just taken
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         hop_index_ff <= HOP_IDX_W'(1);
         bound_ff     <= 1'b0;
         stored_id_ff <= '0;
         idle_ff      <= '0;
         use_data_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hop_index_ff <= hop_index_in;
         bound_ff     <= bound_in;
         stored_id_ff <= stored_id_in;
         idle_ff      <= idle_in;
         use_data_ff  <= use_data_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      row_ff      <= row_in;
      inc_ff      <= inc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Hop table: reload row zero at reset, rewrite one entry a cycle while building
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HOP_LEN; i++) begin
            hop_table_ff[i] <= BASE_ROWS[0][i];
         end
      end else if (state_ff == ST_BUILD) begin
         hop_table_ff[cnt_ff] <= base_fixed[5:0];
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_low_ff      <= PWM_LOW_RESET;
         pwm_high_ff     <= PWM_HIGH_RESET;
         bind_timeout_ff <= BIND_TIMEOUT_RESET;
         data_timeout_ff <= DATA_TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PWM_LOW:      pwm_low_ff      <= csr_data[11:0];
            CSR_PWM_HIGH:     pwm_high_ff     <= csr_data[11:0];
            CSR_BIND_TIMEOUT: bind_timeout_ff <= csr_data;
            CSR_DATA_TIMEOUT: data_timeout_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Binding is sticky
   a_bound_sticky: assert property (@(posedge clock) disable iff (reset)
      bound_ff |=> bound_ff)
      else $error("bound flag cleared after binding");

   // Channel words only come from a bound receiver
   a_chan_when_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.kind == KIND_CHAN) |-> bound_ff)
      else $error("channel word while unbound");

   // The hop index moves only when a retune word is loaded
   a_hop_on_retune: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_RETUNE && out_free) |=> hop_index_ff == $past(hop_index_ff))
      else $error("hop index moved without a retune word");

   // A table rebuild starts only straight after a bind word
   a_build_after_bind: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_BUILD) |-> $past(state_ff == ST_BIND))
      else $error("table rebuild without a bind");

endmodule

`default_nettype wire

// ===== bench/hopping_rc_packet_receiver_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hopping_rc_packet_receiver: ticks and radio packets go in as request
// words, and every result word is compared with a local model of hopping, binding and decode.
// Depends on hrpr_pkg and the receiver core only.

module hopping_rc_packet_receiver_tb;
   import hrpr_pkg::*;

   // Longest run of cycles with no word moving on any channel before the run is abandoned
   localparam int STALL_LIMIT   = 2000;
   // Covers the table rebuild after a bind plus the output register
   localparam int SETTLE_CYCLES = 32;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_PWM_LOW;
   logic [15:0]   csr_data  = '0;

   // Local copy of the receiver state and its registers
   logic [5:0]  hop_tbl [HOP_LEN];
   logic [3:0]  hop_pos;
   logic        is_bound;
   logic [23:0] bound_id;
   logic [16:0] idle_ticks;
   logic        data_mode;
   logic [11:0] pwm_lo;
   logic [11:0] pwm_hi;
   logic [15:0] bind_limit;
   logic [15:0] data_limit;

   rsp_type     due_results [$];   // result words still owed by the receiver, oldest first
   req_type     pending_items [$]; // request words not yet presented
   logic [23:0] link_id;           // transmitter id the receiver binds to
   logic        idling_on;
   int          req_gap;
   int          rsp_gap;
   int          quiet_cycles;
   int          error_count;
   rsp_type     want;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   hopping_rc_packet_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // ---------------------------------------------------------------- model

   function automatic logic [11:0] scale_byte(input logic [7:0] b);
      return 12'((int'(b) * 1000) / 255 + 1000);
   endfunction

   // Sticks below centre are folded back onto the upper half before scaling
   function automatic logic [7:0] fold_stick(input logic [7:0] a);
      return (a < 8'h80) ? 8'h7F - a : a;
   endfunction

   function automatic rsp_type make_word(input logic [1:0] kind, input logic [6:0] rf,
                                         input logic [3:0] chn, input logic [11:0] val);
      rsp_type w;
      w.kind           = kind;
      w.rf_channel     = rf;
      w.channel_number = chn;
      w.channel_value  = val;
      w.last           = 1'b0;
      return w;
   endfunction

   // Work out the result words of one accepted request word and advance the local state
   function automatic void predict_item(input req_type w);
      rsp_type     batch [12];
      int          n;
      int          i;
      logic [15:0] limit;
      logic [7:0]  id_sum;
      logic [7:0]  entry;
      logic [23:0] id;
      logic        bind_bits;
      n         = 0;
      id        = {w.id_third, w.id_second, w.id_first};
      bind_bits = (w.mode_flags & BIND_MASK) == BIND_MASK;
      if (w.cmd == CMD_TICK) begin
         limit = data_mode ? data_limit : bind_limit;
         if (idle_ticks != IDLE_MAX) idle_ticks = idle_ticks + 17'd1;
         // Timed out: hop to the next table entry and restart the count
         if (idle_ticks > {1'b0, limit}) begin
            batch[n]   = make_word(KIND_RETUNE, {1'b0, hop_tbl[hop_pos]}, 4'd0, 12'd0);
            n          = n + 1;
            hop_pos    = hop_pos + 4'd1;
            idle_ticks = '0;
         end
      end else begin
         // Any packet retunes first, using the table as it stood before this packet
         idle_ticks = '0;
         batch[n]   = make_word(KIND_RETUNE, {1'b0, hop_tbl[hop_pos]}, 4'd0, 12'd0);
         n          = n + 1;
         hop_pos    = hop_pos + 4'd1;
         if (!is_bound) begin
            if (bind_bits) begin
               // Take the id and rebuild the table: row from sum[1:0], offset from sum[4:2]
               bound_id = id;
               id_sum   = w.id_first + w.id_second + w.id_third;
               for (i = 0; i < HOP_LEN; i++) begin
                  entry = {2'b00, BASE_ROWS[id_sum[1:0]][i]} + {5'd0, id_sum[4:2]};
                  if (entry[3:0] == 4'h0) entry = entry - HOP_FIX;
                  hop_tbl[i] = entry[5:0];
               end
               is_bound  = 1'b1;
               data_mode = 1'b0;
            end
            batch[n] = make_word(KIND_BIND, 7'd0, 4'd0, 12'd0);
            n        = n + 1;
         end else if (bind_bits) begin
            batch[n] = make_word(KIND_BIND, 7'd0, 4'd0, 12'd0);
            n        = n + 1;
         end else if (id == bound_id) begin
            data_mode  = 1'b1;
            batch[n]   = make_word(KIND_CHAN, 7'd0, CH_THROTTLE, scale_byte(w.throttle_byte));
            batch[n+1] = make_word(KIND_CHAN, 7'd0, CH_YAW, scale_byte(fold_stick(w.yaw_byte)));
            batch[n+2] = make_word(KIND_CHAN, 7'd0, CH_PITCH,
                                   scale_byte(fold_stick(w.pitch_byte)));
            batch[n+3] = make_word(KIND_CHAN, 7'd0, CH_ROLL, scale_byte(fold_stick(w.roll_byte)));
            batch[n+4] = make_word(KIND_CHAN, 7'd0, CH_LED,
                                   ((w.mode_flags & MODE_LED) != 8'h00) ? pwm_hi : pwm_lo);
            batch[n+5] = make_word(KIND_CHAN, 7'd0, CH_FLIP,
                                   ((w.mode_flags & MODE_FLIP) != 8'h00) ? pwm_hi : pwm_lo);
            batch[n+6] = make_word(KIND_CHAN, 7'd0, CH_CAMERA,
                                   ((w.mode_flags & MODE_CAMERA) != 8'h00) ? pwm_hi : pwm_lo);
            batch[n+7] = make_word(KIND_CHAN, 7'd0, CH_VIDEO,
                                   ((w.mode_flags & MODE_VIDEO) != 8'h00) ? pwm_hi : pwm_lo);
            batch[n+8] = make_word(KIND_CHAN, 7'd0, CH_HEADLESS,
                                   ((w.aux_flags & AUX_HEADLESS) != 8'h00) ? pwm_hi : pwm_lo);
            batch[n+9] = make_word(KIND_CHAN, 7'd0, CH_MAG_X,
                                   ((w.aux_flags & AUX_MAG_X) != 8'h00) ? pwm_hi : pwm_lo);
            batch[n+10] = make_word(KIND_CHAN, 7'd0, CH_MAG_Y,
                                    ((w.aux_flags & AUX_MAG_Y) != 8'h00) ? pwm_hi : pwm_lo);
            n = n + 11;
         end
         // A mismatching id leaves only the retune word
      end
      if (n > 0) batch[n-1].last = 1'b1;
      for (i = 0; i < n; i++) due_results.push_back(batch[i]);
   endfunction

   function automatic void check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------- driver

   // Present queued request words; random idle gaps while idling is on
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) predict_item(req_data);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0 && idling_on && $urandom_range(0, 7) == 0) begin
               req_gap   <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // Check each result word against the oldest one owed, and stall the result side at random while idling is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result word with nothing owed: kind %0d rf %0d chn %0d value %0d",
                      rsp_data.kind, rsp_data.rf_channel, rsp_data.channel_number,
                      rsp_data.channel_value);
               error_count++;
            end else begin
               want = due_results.pop_front();
               check_field("kind", want.kind, rsp_data.kind);
               check_field("rf_channel", want.rf_channel, rsp_data.rf_channel);
               check_field("channel_number", want.channel_number, rsp_data.channel_number);
               check_field("channel_value", want.channel_value, rsp_data.channel_value);
               check_field("last", want.last, rsp_data.last);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_gap   <= $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("hopping_rc_packet_receiver_tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   // Random payload; fields the command does not use stay random as noise
   function automatic req_type random_word(input logic cmd);
      logic [95:0] r;
      req_type     w;
      r     = {$urandom, $urandom, $urandom};
      w     = r[$bits(req_type)-1:0];
      w.cmd = cmd;
      return w;
   endfunction

   function automatic req_type make_packet(input logic [23:0] id, input logic [1:0] bind_bits);
      req_type w;
      w                                     = random_word(CMD_PACKET);
      {w.id_third, w.id_second, w.id_first} = id;
      w.mode_flags[7:6]                     = bind_bits;
      return w;
   endfunction

   task automatic push_ticks(input int count);
      for (int i = 0; i < count; i++) pending_items.push_back(random_word(CMD_TICK));
   endtask

   // Hold until every queued word is taken and every owed result has come, then settle
   task automatic wait_drain(input int settle);
      while (pending_items.size() > 0 || req_valid || due_results.size() > 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Register write; update the local copy at the handshake, return on a falling edge
   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PWM_LOW:      pwm_lo     = value[11:0];
         CSR_PWM_HIGH:     pwm_hi     = value[11:0];
         CSR_BIND_TIMEOUT: bind_limit = value;
         CSR_DATA_TIMEOUT: data_limit = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Mostly well-formed data packets for the bound id among tick bursts; the rest near-miss
   // ids, bind requests and fully random packets. Pause once halfway until all results are in.
   task automatic queue_random_traffic(input int count);
      int   made;
      int   pick;
      int   burst;
      logic paused;
      made   = 0;
      paused = 1'b0;
      while (made < count) begin
         if (!paused && made >= count / 2) begin
            wait_drain(0);
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            burst = $urandom_range(1, 12);
            push_ticks(burst);
            made = made + burst;
         end else begin
            if (pick < 80)
               pending_items.push_back(make_packet(link_id, 2'($urandom_range(0, 2))));
            else if (pick < 88)
               pending_items.push_back(make_packet(link_id ^ (24'd1 << $urandom_range(0, 23)),
                                                   2'($urandom_range(0, 2))));
            else if (pick < 94)
               pending_items.push_back(make_packet(24'($urandom), 2'b11));
            else
               pending_items.push_back(make_packet(24'($urandom), 2'($urandom)));
            made = made + 1;
         end
      end
   endtask

   initial begin
      req_type w;
      // Local state as after reset: table row zero, entry zero already tuned
      for (int i = 0; i < HOP_LEN; i++) hop_tbl[i] = BASE_ROWS[0][i];
      hop_pos     = 4'd1;
      is_bound    = 1'b0;
      bound_id    = '0;
      idle_ticks  = '0;
      data_mode   = 1'b0;
      pwm_lo      = PWM_LOW_RESET;
      pwm_hi      = PWM_HIGH_RESET;
      bind_limit  = BIND_TIMEOUT_RESET;
      data_limit  = DATA_TIMEOUT_RESET;
      error_count = 0;
      idling_on   = 1'b1;
      link_id     = 24'($urandom);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Unbound, register defaults: a few ticks stay under the bind timeout,
      // and packets with only one bind bit give a bind word without binding
      push_ticks(5);
      pending_items.push_back(make_packet(link_id, 2'b10));
      pending_items.push_back(make_packet(link_id, 2'b01));

      // Zero timeout: hop on every tick, wrapping the index
      wait_drain(SETTLE_CYCLES);
      write_csr(CSR_BIND_TIMEOUT, 16'd0);
      push_ticks(18);

      // Largest timeout gives no hop; a short one hops only after the count passes it
      wait_drain(SETTLE_CYCLES);
      write_csr(CSR_BIND_TIMEOUT, 16'hFFFF);
      push_ticks(4);
      wait_drain(SETTLE_CYCLES);
      write_csr(CSR_BIND_TIMEOUT, 16'd5);
      push_ticks(9);

      // Bind, then walk the rebuilt table on the bind timeout
      wait_drain(SETTLE_CYCLES);
      write_csr(CSR_BIND_TIMEOUT, 16'd3);
      pending_items.push_back(make_packet(link_id, 2'b11));
      push_ticks(36);
      // Bound: a second bind request, a foreign id and a one-bit miss
      pending_items.push_back(make_packet(link_id, 2'b11));
      pending_items.push_back(make_packet(~link_id, 2'b00));
      pending_items.push_back(make_packet(link_id ^ 24'h800000, 2'b00));

      // Data packets at the stick extremes, all switches set then all clear
      wait_drain(SETTLE_CYCLES);
      write_csr(CSR_PWM_LOW, 16'd0);
      write_csr(CSR_PWM_HIGH, 16'd4000);
      write_csr(CSR_DATA_TIMEOUT, 16'd0);
      w               = make_packet(link_id, 2'b00);
      w.throttle_byte = 8'h00;
      w.yaw_byte      = 8'h00;
      w.pitch_byte    = 8'h7F;
      w.roll_byte     = 8'h80;
      w.mode_flags    = 8'h3F;
      w.aux_flags     = 8'hFF;
      pending_items.push_back(w);
      w               = make_packet(link_id, 2'b00);
      w.throttle_byte = 8'hFF;
      w.yaw_byte      = 8'hFF;
      w.pitch_byte    = 8'h01;
      w.roll_byte     = 8'h7E;
      w.mode_flags    = 8'h00;
      w.aux_flags     = 8'h00;
      pending_items.push_back(w);
      pending_items.push_back(make_packet(link_id, 2'b10));
      push_ticks(5);

      // Swapped switch levels, upper data bits dropped, and the largest data timeout
      wait_drain(SETTLE_CYCLES);
      write_csr(CSR_PWM_LOW, 16'd4000);
      write_csr(CSR_PWM_HIGH, 16'hF123);
      write_csr(CSR_DATA_TIMEOUT, 16'hFFFF);
      pending_items.push_back(make_packet(link_id, 2'b01));
      push_ticks(6);
      pending_items.push_back(make_packet(link_id, 2'b00));
      wait_drain(SETTLE_CYCLES);
      write_csr(CSR_PWM_LOW, 16'hFFFF);
      pending_items.push_back(make_packet(link_id, 2'b00));
      wait_drain(SETTLE_CYCLES);
      write_csr(CSR_PWM_LOW, 16'd4000);
      pending_items.push_back(make_packet(link_id, 2'b00));

      // Random phases with short data timeouts so hops are frequent; the last has no idling
      for (int phase = 0; phase < 4; phase++) begin
         wait_drain(SETTLE_CYCLES);
         idling_on = (phase != 3);
         write_csr(CSR_PWM_LOW, 16'($urandom_range(0, 4000)));
         write_csr(CSR_PWM_HIGH, 16'($urandom_range(0, 4000)));
         write_csr(CSR_BIND_TIMEOUT, 16'($urandom));
         case (phase)
            0:       write_csr(CSR_DATA_TIMEOUT, 16'($urandom_range(1, 8)));
            1:       write_csr(CSR_DATA_TIMEOUT, 16'd0);
            2:       write_csr(CSR_DATA_TIMEOUT, 16'($urandom_range(10, 40)));
            default: write_csr(CSR_DATA_TIMEOUT, 16'($urandom_range(1, 4)));
         endcase
         queue_random_traffic(85);
      end

      wait_drain(SETTLE_CYCLES);
      if (due_results.size() != 0) begin
         $error("%0d result words never arrived", due_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("hopping_rc_packet_receiver_tb: done, clean");
      else
         $display("hopping_rc_packet_receiver_tb: done, errors");
      $finish;
   end

endmodule
